/* sv/gdad_pkg.sv */
package gdad_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int FWD_W    = 16;
	localparam int STATUS_W = 2;
	localparam int REM_W    = 17;
	localparam int Q100_W   = 8;
	localparam int R100_W   = 7;
	localparam int R400_W   = 9;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	localparam logic [YEAR_W-1:0] MIN_YEAR = 14'd1900;

	// floor(y / 100) = (y * 5243) >> 19 holds for every 14-bit year.
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [R100_W-1:0] R100_LAST = 7'd99;
	localparam logic [R400_W-1:0] R400_LAST = 9'd399;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_BAD_YEAR  = 2'd1,
		STS_BAD_MONTH = 2'd2,
		STS_BAD_DAY   = 2'd3
	} gdad_status_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic calc;
		logic init;
		logic step;
		logic finish;
	} gdad_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic done;
	} gdad_sts_t;

	// Length of a month in a common year; codes outside 1 to 12 give zero.
	function automatic logic [DAY_W-1:0] common_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

/* sv/gregorian_date_add_days.sv */
// The month walk steps once per month boundary crossed (up to about 2160 for a
// 65535-day offset); invalid dates skip the walk. One item is handled at a time:
// a new input beat is taken only in idle, after the last result has been stored.
// A finished result waits in the output register; the next one waits until it is taken.
// Reset (arst_n low, asynchronous) clears the sequencer and the output valid flag.
module gregorian_date_add_days (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// From bit 0 up: start_year[13:0], start_month[17:14], start_day[22:18],
	// days_forward[38:23], zero pad [39].
	input  logic [gdad_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// From bit 0 up: end_year[13:0], end_month[17:14], end_day[22:18],
	// date_status[24:23], zero pad [31:25].
	output logic [gdad_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
	import gdad_pkg::*;

	gdad_cmd_t           cmd;
	gdad_sts_t           sts;
	logic [YEAR_W-1:0]   end_year;
	logic [MONTH_W-1:0]  end_month;
	logic [DAY_W-1:0]    end_day;
	logic [STATUS_W-1:0] date_status;

	// The sequencer loads an item, computes the year's residues in its CALC and INIT
	// states, then steps the datapath one month per cycle until the remaining day
	// count fits in the current month. It returns to idle once the result is stored.
	gdad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the working date, the remaining day count, and the
	// year's residues mod 100 and 400 that drive the leap-year test.
	gdad_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.start_year   (s_axis_tdata[13:0]),
		.start_month  (s_axis_tdata[17:14]),
		.start_day    (s_axis_tdata[22:18]),
		.days_forward (s_axis_tdata[38:23]),
		.end_year     (end_year),
		.end_month    (end_month),
		.end_day      (end_day),
		.date_status  (date_status)
	);

	assign m_axis_tdata = {7'd0, date_status, end_day, end_month, end_year};

	// The block is busy in the cycle after an input beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while the block was still busy");

	// A newly presented result coincides with the block going back to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result presented while the block was not idle");

	// A good date always yields a real month and day.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[24:23] == STS_OK) |->
		(m_axis_tdata[22:18] != 5'd0 && m_axis_tdata[17:14] != 4'd0 &&
		 m_axis_tdata[17:14] <= MONTH_DEC))
		else $error("valid result carries an impossible date");

endmodule

/* sv/gdad_ctrl.sv */
module gdad_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gdad_pkg::gdad_sts_t sts,
	output gdad_pkg::gdad_cmd_t cmd
);
	import gdad_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_INIT = 4'b0100,
		ST_WALK = 4'b1000
	} gdad_state_t;

	gdad_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_WALK;
			end
			ST_WALK: begin
				if (!sts.done) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/gdad_dp.sv */
module gdad_dp (
	input  logic                                   clk,
	input  gdad_pkg::gdad_cmd_t                    cmd,
	output gdad_pkg::gdad_sts_t                    sts,
	input  logic [gdad_pkg::YEAR_W-1:0]            start_year,
	input  logic [gdad_pkg::MONTH_W-1:0]           start_month,
	input  logic [gdad_pkg::DAY_W-1:0]             start_day,
	input  logic [gdad_pkg::FWD_W-1:0]             days_forward,
	output logic [gdad_pkg::YEAR_W-1:0]            end_year,
	output logic [gdad_pkg::MONTH_W-1:0]           end_month,
	output logic [gdad_pkg::DAY_W-1:0]             end_day,
	output logic [gdad_pkg::STATUS_W-1:0]          date_status
);
	import gdad_pkg::*;

	logic [YEAR_W-1:0]   year_q;
	logic [MONTH_W-1:0]  month_q;
	logic [DAY_W-1:0]    day_q;
	logic [REM_W-1:0]    rem_q;
	logic [Q100_W-1:0]   q100_q;
	logic [R100_W-1:0]   r100_q;
	logic [R400_W-1:0]   r400_q;
	gdad_status_t        status_q;

	logic [YEAR_W-1:0]   out_year_q;
	logic [MONTH_W-1:0]  out_month_q;
	logic [DAY_W-1:0]    out_day_q;
	gdad_status_t        out_status_q;

	gdad_status_t        check;
	logic [26:0]         recip_prod;
	logic [YEAR_W-1:0]   sub100;
	logic [YEAR_W-1:0]   sub400;
	logic                leap;
	logic [DAY_W-1:0]    len;
	logic [DAY_W-1:0]    day_len;

	// Date checks, first failing one wins.
	assign day_len = common_len(month_q);
	always_comb begin
		if (year_q < MIN_YEAR) begin
			check = STS_BAD_YEAR;
		end else if (month_q < MONTH_JAN || month_q > MONTH_DEC) begin
			check = STS_BAD_MONTH;
		end else if (day_q == '0 || day_q > day_len) begin
			check = STS_BAD_DAY;
		end else begin
			check = STS_OK;
		end
	end

	assign recip_prod = 27'(year_q) * 27'(RECIP_100);
	assign sub100     = year_q - 14'(q100_q) * 14'd100;
	assign sub400     = year_q - 14'(q100_q[Q100_W-1:2]) * 14'd400;

	// The year's residues mod 100 and 400 are tracked as counters during the walk.
	assign leap = ((year_q[1:0] == 2'd0) && (r100_q != '0)) || (r400_q == '0);
	assign len  = (month_q == MONTH_FEB && leap) ? 5'd29 : day_len;

	assign sts.done = (status_q != STS_OK) || (rem_q <= REM_W'(len));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= start_year;
			month_q <= start_month;
			day_q   <= start_day;
			rem_q   <= REM_W'(start_day) + REM_W'(days_forward);
		end
		if (cmd.calc) begin
			q100_q   <= recip_prod[RECIP_SHIFT +: Q100_W];
			status_q <= check;
		end
		if (cmd.init) begin
			r100_q <= sub100[R100_W-1:0];
			r400_q <= sub400[R400_W-1:0];
		end
		if (cmd.step) begin
			rem_q <= rem_q - REM_W'(len);
			if (month_q == MONTH_DEC) begin
				month_q <= MONTH_JAN;
				year_q  <= year_q + 14'd1;
				r100_q  <= (r100_q == R100_LAST) ? '0 : r100_q + 7'd1;
				r400_q  <= (r400_q == R400_LAST) ? '0 : r400_q + 9'd1;
			end else begin
				month_q <= month_q + 4'd1;
			end
		end
		if (cmd.finish) begin
			out_year_q   <= year_q;
			out_month_q  <= month_q;
			out_day_q    <= (status_q == STS_OK) ? rem_q[DAY_W-1:0] : day_q;
			out_status_q <= status_q;
		end
	end

	assign end_year    = out_year_q;
	assign end_month   = out_month_q;
	assign end_day     = out_day_q;
	assign date_status = out_status_q;

endmodule

/* verif/tb_gregorian_date_add_days.sv */
`timescale 1ns / 1ps

// Testbench for gregorian_date_add_days.
//
// A start date and a day offset go in as one beat on the slave side. One result beat comes
// back on the master side: the date advanced month by month, or the start date unchanged
// with the code of the first failing check. Every accepted input beat is run through a
// behavioral predictor in this file. The expected result is queued, and each output beat
// is compared field by field against the head of that queue.
//
// Handshakes are sampled at the falling edge. The block only changes its outputs at rising
// edges, so the value seen there is the value present at the next rising edge, whatever
// the order of events within that step.
module tb_gregorian_date_add_days;
	import gdad_pkg::*;

	// One input beat. The last field sits in the lowest bits, as on s_axis_tdata.
	typedef struct packed {
		logic                 pad;
		logic [FWD_W-1:0]     days_forward;
		logic [DAY_W-1:0]     start_day;
		logic [MONTH_W-1:0]   start_month;
		logic [YEAR_W-1:0]    start_year;
	} date_req_t;

	// One output beat, laid out like m_axis_tdata.
	typedef struct packed {
		logic [6:0]           pad;
		gdad_status_t         date_status;
		logic [DAY_W-1:0]     end_day;
		logic [MONTH_W-1:0]   end_month;
		logic [YEAR_W-1:0]    end_year;
	} date_res_t;

	// Month lengths in a common year. Codes 0 and 13 to 15 are not months, so they get
	// zero, and any 4-bit code can be used as an index.
	localparam int unsigned COMMON_DAYS [16] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31,
		0, 0, 0};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	date_res_t pending_dates [$];   // expected result beats, oldest first
	int        err_count;
	int        dates_sent;
	bit        steady;              // when set, neither side idles
	int        rx_hold_cycles;      // receiver holds tready low this many cycles

	gregorian_date_add_days uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Checks the date in the order year, month, day. A valid date is then walked forward
	// one month at a time. February gets its extra day in Gregorian leap years.
	function automatic date_res_t advance_date(input date_req_t req);
		date_res_t   res;
		int unsigned yr;
		int unsigned mon;
		int unsigned rem;
		int unsigned len;
		res = '0;
		yr  = req.start_year;
		mon = req.start_month;
		rem = req.start_day;
		res.date_status = STS_OK;
		if (yr < MIN_YEAR)
			res.date_status = STS_BAD_YEAR;
		else if (mon < MONTH_JAN || mon > MONTH_DEC)
			res.date_status = STS_BAD_MONTH;
		else if (rem < 1 || rem > COMMON_DAYS[mon])
			res.date_status = STS_BAD_DAY;
		if (res.date_status == STS_OK) begin
			rem += req.days_forward;
			forever begin
				len = COMMON_DAYS[mon];
				if (mon == MONTH_FEB &&
						(((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)))
					len++;
				if (rem <= len)
					break;
				rem -= len;
				mon = (mon == MONTH_DEC) ? MONTH_JAN : mon + 1;
				if (mon == MONTH_JAN)
					yr++;
			end
		end
		// The end year wraps modulo 2^14 when a large start year crosses the top.
		res.end_year  = YEAR_W'(yr);
		res.end_month = MONTH_W'(mon);
		res.end_day   = DAY_W'(rem);
		return res;
	endfunction

	function automatic date_req_t make_date(input int unsigned yr, input int unsigned mon,
			input int unsigned day, input int unsigned fwd);
		date_req_t req;
		req = '0;
		req.start_year   = YEAR_W'(yr);
		req.start_month  = MONTH_W'(mon);
		req.start_day    = DAY_W'(day);
		req.days_forward = FWD_W'(fwd);
		return req;
	endfunction

	// Most random dates are valid, since only those reach the month walk. Their offsets are
	// mostly short, which keeps the run fast, with a share of full 16-bit offsets. The
	// rest break one check at a time, or are raw bits.
	function automatic date_req_t random_date();
		int unsigned yr;
		int unsigned mon;
		int unsigned day;
		int unsigned fwd;
		int unsigned pick;
		yr   = ($urandom_range(99) < 70) ? $urandom_range(1900, 2500) : $urandom_range(1900, 16383);
		mon  = $urandom_range(MONTH_JAN, MONTH_DEC);
		day  = ($urandom_range(99) < 20) ? COMMON_DAYS[mon] : $urandom_range(1, COMMON_DAYS[mon]);
		pick = $urandom_range(99);
		if (pick < 60)
			fwd = $urandom_range(0, 400);
		else if (pick < 85)
			fwd = $urandom_range(0, 4000);
		else
			fwd = $urandom_range(0, 65535);
		pick = $urandom_range(99);
		if (pick < 5)
			yr = $urandom_range(0, MIN_YEAR - 1);
		else if (pick < 10)
			mon = ($urandom_range(3) == 0) ? 0 : $urandom_range(MONTH_DEC + 1, 15);
		else if (pick < 15)
			day = ($urandom_range(1) == 0) ? 0 : $urandom_range(COMMON_DAYS[mon] + 1, 31);
		else if (pick < 20) begin
			yr  = $urandom_range(0, 16383);
			mon = $urandom_range(0, 15);
			day = $urandom_range(0, 31);
		end
		return make_date(yr, mon, day, fwd);
	endfunction

	// Offers one input beat and returns at the rising edge that accepts it. The caller is
	// always at a rising edge here, and tvalid gets only one update per step.
	task automatic offer_date(input date_req_t req);
		bit took;
		if (!steady && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		pending_dates.push_back(advance_date(req));
		dates_sent++;
	endtask

	// Drops tvalid and waits for every expected result. The guard covers the longest month
	// walk plus receiver stalls. Anything left in the queue is reported at the end.
	task automatic drain_dates();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_dates.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	// Status codes in check order. A broken year wins over a broken month, and a broken
	// month wins over a broken day. 29 February is rejected even in a leap year.
	task automatic test_invalid_dates();
		offer_date(make_date(0, 1, 1, 5));
		offer_date(make_date(MIN_YEAR - 1, 13, 0, 10));
		offer_date(make_date(1900, 0, 1, 0));
		offer_date(make_date(2000, 13, 1, 1));
		offer_date(make_date(2000, 15, 0, 65535));
		offer_date(make_date(2000, 4, 31, 3));
		offer_date(make_date(2000, 2, 29, 1));
		offer_date(make_date(2000, 6, 0, 7));
		drain_dates();
	endtask

	// A zero offset hands a valid date back as it is, the extremes of the fields included.
	task automatic test_zero_offset();
		offer_date(make_date(1900, 1, 1, 0));
		offer_date(make_date(16383, 12, 31, 0));
		offer_date(make_date(2023, 7, 31, 0));
		drain_dates();
	endtask

	// Leap rules at the century years, year rollover, and the longest walks. Two of them
	// start near the top of the year field, so the end year wraps.
	task automatic test_month_walk();
		offer_date(make_date(2000, 2, 28, 1));
		offer_date(make_date(1900, 2, 28, 1));
		offer_date(make_date(2100, 2, 28, 1));
		offer_date(make_date(2400, 2, 28, 1));
		offer_date(make_date(2024, 12, 31, 1));
		offer_date(make_date(2023, 1, 31, 28));
		offer_date(make_date(2024, 1, 31, 29));
		offer_date(make_date(1900, 1, 1, 65535));
		offer_date(make_date(9999, 12, 31, 65535));
		offer_date(make_date(16383, 12, 31, 1));
		offer_date(make_date(16383, 1, 31, 65535));
		drain_dates();
	endtask

	// The receiver stalls for a long stretch while valid dates keep coming. The block fills
	// and must hold its input off until the receiver resumes.
	task automatic test_backpressure();
		rx_hold_cycles = 400;
		repeat (12)
			offer_date(make_date($urandom_range(1900, 2100), 3, 15, $urandom_range(0, 60)));
		drain_dates();
	endtask

	// Random dates. The first stretch runs with both sides always ready. The rest runs
	// with random idling on both sides, and with one pause halfway for the queue to empty.
	task automatic test_random_dates(input int count);
		steady = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (i == 60)
				steady = 1'b0;
			if (i == count / 2)
				drain_dates();
			offer_date(random_date());
		end
		drain_dates();
	endtask

	// Receiver: random stalls unless steady. A requested hold is counted down here.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 15);
			end
		end
	end

	// Result checker. A beat seen valid and ready here is accepted at the next rising edge.
	always @(negedge clk) begin
		date_res_t got;
		date_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = date_res_t'(m_axis_tdata);
			if (pending_dates.size() == 0) begin
				$error("result beat with no date pending: %h", m_axis_tdata);
				err_count++;
			end else begin
				want = pending_dates.pop_front();
				if (got.end_year !== want.end_year) begin
					$error("end_year: expected %0d, actual %0d", want.end_year, got.end_year);
					err_count++;
				end
				if (got.end_month !== want.end_month) begin
					$error("end_month: expected %0d, actual %0d", want.end_month, got.end_month);
					err_count++;
				end
				if (got.end_day !== want.end_day) begin
					$error("end_day: expected %0d, actual %0d", want.end_day, got.end_day);
					err_count++;
				end
				if (got.date_status !== want.date_status) begin
					$error("date_status: expected %0d, actual %0d", want.date_status,
						got.date_status);
					err_count++;
				end
			end
		end
	end

	// Safety limit, well beyond the slowest correct run.
	initial begin
		#60_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		err_count      = 0;
		dates_sent     = 0;
		steady         = 1'b0;
		rx_hold_cycles = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_invalid_dates();
		test_zero_offset();
		test_month_walk();
		test_backpressure();
		test_random_dates(237);

		if (pending_dates.size() != 0) begin
			$error("%0d expected result beats never arrived", pending_dates.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
